// ----- hdl/mcpt_pkg.sv -----
// ----------------------------------------------------------------------------
// mcpt_pkg
// Shared types, register codes and helpers for the MACD crossover tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package mcpt_pkg;

  // Quotient bits retired per divider cycle
  localparam int DIV_RADIX_BITS = 4;
  // Divisor is period + 1, so 1..256
  localparam int DVS_W          = 9;
  localparam int PERIOD_W       = 8;
  localparam int LIMIT_W        = 10;
  localparam int POS_W          = 11;
  localparam int CASH_W         = 48;
  localparam int SIG_OUT_W      = 41;
  localparam int ACT_W          = 2;
  localparam int IN_DATA_W      = 24;
  localparam int OUT_DATA_W     = 192;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_ADDR_W     = 4;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_BUY  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SELL = 2'd2;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_LIMIT  = 2'd0;
  localparam logic [1:0] REG_SHORT  = 2'd1;
  localparam logic [1:0] REG_LONG   = 2'd2;
  localparam logic [1:0] REG_SIGNAL = 2'd3;

  // Register reset values
  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 10'd1;
  localparam logic [PERIOD_W-1:0] SHORT_RST  = 8'd12;
  localparam logic [PERIOD_W-1:0] LONG_RST   = 8'd26;
  localparam logic [PERIOD_W-1:0] SIGNAL_RST = 8'd9;

  // Which average the shared divider is working on
  localparam logic [1:0] SEL_FAST = 2'd0;
  localparam logic [1:0] SEL_SLOW = 2'd1;
  localparam logic [1:0] SEL_SIG  = 2'd2;

  localparam logic signed [CASH_W-1:0] CASH_MAX = {1'b0, {(CASH_W-1){1'b1}}};
  localparam logic signed [CASH_W-1:0] CASH_MIN = {1'b1, {(CASH_W-1){1'b0}}};

  typedef struct packed {
    logic [LIMIT_W-1:0]  position_limit;
    logic [PERIOD_W-1:0] short_period;
    logic [PERIOD_W-1:0] long_period;
    logic [PERIOD_W-1:0] signal_period;
  } cfg_t;

  typedef struct packed {
    logic       load_in;
    logic       load_first;
    logic       div_start;
    logic [1:0] div_sel;
    logic       wr_avg;
    logic       calc_macd;
    logic       trade;
    logic       mul;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_sts_t;

  // Saturate a one-bit-grown sum back to the 48-bit signed range
  function automatic logic signed [CASH_W-1:0] sat_cash(input logic signed [CASH_W:0] v);
    if (v[CASH_W] != v[CASH_W-1]) begin
      return v[CASH_W] ? CASH_MIN : CASH_MAX;
    end
    return v[CASH_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/mcpt_divider.sv -----
// ----------------------------------------------------------------------------
// mcpt_divider
// Iterative unsigned divider, DIV_RADIX_BITS quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mcpt_divider
  import mcpt_pkg::*;
#(
  parameter int DVD_W = 42
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic [DVD_W-1:0]      quotient
);

  localparam int NSTEP = (DVD_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
  localparam int PAD_W = NSTEP * DIV_RADIX_BITS;
  localparam int CNT_W = $clog2(NSTEP + 1);

  logic [PAD_W-1:0] q_r, q_nxt;
  logic [DVS_W-2:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W-1:0] trial;

  // Restoring steps: dividend shifts out the top, quotient bits shift in
  always_comb begin
    q_nxt   = q_r;
    rem_nxt = rem_r;
    trial   = '0;
    for (int i = 0; i < DIV_RADIX_BITS; i++) begin
      trial = {rem_nxt, q_nxt[PAD_W-1]};
      q_nxt = {q_nxt[PAD_W-2:0], 1'b0};
      if (trial >= dvs_r) begin
        trial    = trial - dvs_r;
        q_nxt[0] = 1'b1;
      end
      rem_nxt = trial[DVS_W-2:0];
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NSTEP);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= PAD_W'(dividend);
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r[DVD_W-1:0];

  // A new operand must never land on a division in flight
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider restarted while busy");

endmodule

`default_nettype wire

// ----- hdl/mcpt_datapath.sv -----
// ----------------------------------------------------------------------------
// mcpt_datapath
// Averages, MACD, signal, position, cashflow and net value registers.
// ----------------------------------------------------------------------------
`default_nettype none

module mcpt_datapath
  import mcpt_pkg::*;
#(
  parameter int FRAC_BITS  = 16,
  parameter int PRICE_BITS = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire dp_cmd_t               cmd,
  output dp_sts_t                    sts,
  input  wire cfg_t                  cfg,
  input  wire logic [IN_DATA_W-1:0]  in_price,
  output logic [OUT_DATA_W-1:0]      out_data
);

  localparam int AVG_W  = PRICE_BITS + FRAC_BITS;
  localparam int MAC_W  = AVG_W + 1;
  localparam int AW     = AVG_W + 4;
  localparam int DVD_W  = AVG_W + 2;
  localparam int PROD_W = PRICE_BITS + POS_W + 1;

  localparam logic [AVG_W-1:0]     AMAX   = {{PRICE_BITS{1'b1}}, {FRAC_BITS{1'b0}}};
  localparam logic signed [AW-1:0] AMAX_S = {4'b0000, AMAX};

  logic [PRICE_BITS-1:0]          price_r;
  logic [AVG_W-1:0]               fast_r;
  logic [AVG_W-1:0]               slow_r;
  logic signed [MAC_W-1:0]        sig_r;
  logic signed [MAC_W-1:0]        macd_r;
  logic                           neg_r;
  logic signed [POS_W-1:0]        units_r;
  logic signed [CASH_W-1:0]       cash_r;
  logic [ACT_W-1:0]               action_r;
  logic signed [PROD_W-1:0]       prod_r;
  logic [OUT_DATA_W-1:0]          out_data_r;

  logic [AVG_W-1:0]               pfix;
  logic signed [AW-1:0]           avg_s;
  logic signed [AW-1:0]           tgt_s;
  logic [DVS_W-1:0]               dvs;
  logic signed [AW-1:0]           delta2;
  logic [DVD_W-1:0]               dvd_mag;
  logic [DVD_W-1:0]               quot;
  logic                           div_done;
  logic signed [AW-1:0]           q_ext;
  logic signed [AW-1:0]           q_s;
  logic signed [AW-1:0]           upd;
  logic signed [AW-1:0]           lo;
  logic signed [AW-1:0]           clamped;
  logic signed [POS_W-1:0]        limit_s;
  logic                           buy;
  logic                           sell;
  logic signed [CASH_W:0]         cash_ext;
  logic signed [CASH_W:0]         price_ext;
  logic signed [CASH_W:0]         net_sum;
  logic signed [CASH_W-1:0]       net;

  assign pfix = {price_r, {FRAC_BITS{1'b0}}};

  // Operand select for the average being updated
  always_comb begin
    case (cmd.div_sel)
      SEL_FAST: begin
        avg_s = {4'b0000, fast_r};
        tgt_s = {4'b0000, pfix};
        dvs   = {1'b0, cfg.short_period} + DVS_W'(1);
      end
      SEL_SLOW: begin
        avg_s = {4'b0000, slow_r};
        tgt_s = {4'b0000, pfix};
        dvs   = {1'b0, cfg.long_period} + DVS_W'(1);
      end
      default: begin
        avg_s = AW'(sig_r);
        tgt_s = AW'(macd_r);
        dvs   = {1'b0, cfg.signal_period} + DVS_W'(1);
      end
    endcase
  end

  // 2*(target - avg), split into magnitude and sign for the divider
  assign delta2  = (tgt_s - avg_s) <<< 1;
  assign dvd_mag = delta2[AW-1] ? DVD_W'(-delta2) : DVD_W'(delta2);

  mcpt_divider #(
    .DVD_W (DVD_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd_mag),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quot)
  );

  assign sts.div_done = div_done;

  // Truncated quotient with sign restored, added back and clamped
  assign q_ext = {{(AW-DVD_W){1'b0}}, quot};
  assign q_s   = neg_r ? -q_ext : q_ext;
  assign upd   = avg_s + q_s;
  assign lo    = (cmd.div_sel == SEL_SIG) ? -AMAX_S : '0;

  always_comb begin
    if (upd < lo) begin
      clamped = lo;
    end else if (upd > AMAX_S) begin
      clamped = AMAX_S;
    end else begin
      clamped = upd;
    end
  end

  // Trade decision
  assign limit_s   = $signed({1'b0, cfg.position_limit});
  assign buy       = (macd_r > sig_r) && (units_r < limit_s);
  assign sell      = (macd_r < sig_r) && (units_r > -limit_s);
  assign cash_ext  = {cash_r[CASH_W-1], cash_r};
  assign price_ext = (CASH_W+1)'(price_r);
  assign net_sum   = cash_ext + (CASH_W+1)'(prod_r);
  assign net       = sat_cash(net_sum);

  // Price, averages, MACD, product and output record
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      price_r <= PRICE_BITS'(in_price);
    end
    if (cmd.div_start) begin
      neg_r <= delta2[AW-1];
    end
    if (cmd.load_first) begin
      fast_r <= pfix;
      slow_r <= pfix;
      sig_r  <= '0;
      macd_r <= '0;
    end else if (cmd.wr_avg) begin
      case (cmd.div_sel)
        SEL_FAST: fast_r <= clamped[AVG_W-1:0];
        SEL_SLOW: slow_r <= clamped[AVG_W-1:0];
        default:  sig_r  <= clamped[MAC_W-1:0];
      endcase
    end else if (cmd.calc_macd) begin
      macd_r <= $signed({1'b0, fast_r}) - $signed({1'b0, slow_r});
    end
    if (cmd.mul) begin
      prod_r <= $signed({1'b0, price_r}) * units_r;
    end
    if (cmd.out_load) begin
      out_data_r <= {1'b0, net, cash_r, units_r, action_r,
                     SIG_OUT_W'(sig_r), SIG_OUT_W'(macd_r)};
    end
  end

  // Position, cashflow and action
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      units_r  <= '0;
      cash_r   <= '0;
      action_r <= ACT_NONE;
    end else if (cmd.trade) begin
      if (buy) begin
        action_r <= ACT_BUY;
        units_r  <= units_r + POS_W'(1);
        cash_r   <= sat_cash(cash_ext - price_ext);
      end else if (sell) begin
        action_r <= ACT_SELL;
        units_r  <= units_r - POS_W'(1);
        cash_r   <= sat_cash(cash_ext + price_ext);
      end else begin
        action_r <= ACT_NONE;
      end
    end
  end

  assign out_data = out_data_r;

  a_fast_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_avg && cmd.div_sel == SEL_FAST) |=> (fast_r <= AMAX))
    else $error("fast average above its clamp");

  a_units_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.trade |=> (units_r == $past(units_r)) ||
                  (units_r == $past(units_r) + POS_W'(1)) ||
                  (units_r == $past(units_r) - POS_W'(1)))
    else $error("position moved by more than one unit");

endmodule

`default_nettype wire

// ----- hdl/mcpt_ctrl.sv -----
// ----------------------------------------------------------------------------
// mcpt_ctrl
// Sequencer: input transfer, three divisions, trade, net value, output.
// ----------------------------------------------------------------------------
`default_nettype none

module mcpt_ctrl
  import mcpt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_tvalid,
  output logic         in_tready,
  output logic         out_tvalid,
  input  wire logic    out_tready,
  output dp_cmd_t      cmd,
  input  wire dp_sts_t sts
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FIRST = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_MACD  = 3'd4;
  localparam logic [2:0] ST_TRADE = 3'd5;
  localparam logic [2:0] ST_MUL   = 3'd6;
  localparam logic [2:0] ST_NET   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [1:0] sel_r, sel_nxt;
  logic       seen_r, seen_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_tready;

  // Next state and commands
  always_comb begin
    cmd           = '0;
    cmd.div_sel   = sel_r;
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    seen_nxt      = seen_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          sel_nxt     = SEL_FAST;
          state_nxt   = seen_r ? ST_DIV : ST_FIRST;
        end
      end
      ST_FIRST: begin
        cmd.load_first = 1'b1;
        seen_nxt       = 1'b1;
        state_nxt      = ST_TRADE;
      end
      ST_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_WAIT;
      end
      ST_WAIT: begin
        if (sts.div_done) begin
          cmd.wr_avg = 1'b1;
          case (sel_r)
            SEL_FAST: begin
              sel_nxt   = SEL_SLOW;
              state_nxt = ST_DIV;
            end
            SEL_SLOW: state_nxt = ST_MACD;
            default:  state_nxt = ST_TRADE;
          endcase
        end
      end
      ST_MACD: begin
        cmd.calc_macd = 1'b1;
        sel_nxt       = SEL_SIG;
        state_nxt     = ST_DIV;
      end
      ST_TRADE: begin
        cmd.trade = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_NET;
      end
      ST_NET: begin
        // hold here until the output register is free
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sel_r       <= SEL_FAST;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == ST_WAIT))
    else $error("divider finished outside the wait state");

  a_first_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !seen_r) |=> (state_r == ST_FIRST))
    else $error("first sample did not take the load path");

  a_div_sel_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |=> (state_r == ST_WAIT) && $stable(sel_r))
    else $error("operand select changed during a division");

endmodule

`default_nettype wire

// ----- hdl/macd_crossover_position_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// macd_crossover_position_tracker_unit
// MACD crossover trader: one price in, one trade/position/value record out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one price sample per transfer (in_tdata[23:0] = price).
//   out_* : one result per sample: MACD, signal, action, position, cashflow
//           and saturated net value, packed in out_tdata.
//   cfg_* : APB-style register port; position_limit at 0x0, short_period at
//           0x4, long_period at 0x8, signal_period at 0xC. Write while idle.
// Sequencing:
//   Samples are handled one at a time. The three average updates share one
//   iterative divider (4 quotient bits per cycle, NSTEP =
//   ceil((PRICE_BITS+FRAC_BITS+2)/4) steps, 11 by default); the first sample
//   after reset takes no division. in_tready rises with out_tvalid, so a new
//   sample is taken only once the last result is in the output register.
// Reset:
//   rst_n (synchronous) restores register defaults, clears position and
//   cashflow, and makes the next sample the first one.
// Backpressure:
//   A finished result sits in the output register; the next sample can be
//   taken meanwhile, but its result waits until out_tready drains the first.
// ----------------------------------------------------------------------------
`default_nettype none

module macd_crossover_position_tracker_unit
  import mcpt_pkg::*;
#(
  parameter int FRAC_BITS  = 16,
  parameter int PRICE_BITS = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [23:0] price
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [40:0] macd_value,
                                                 // [81:41] signal_value,
                                                 // [83:82] action,
                                                 // [94:84] position,
                                                 // [142:95] cashflow,
                                                 // [190:143] net_value
  // configuration port
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  cfg_t    cfg_r;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    cfg_wr;
  logic [1:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  // Register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.position_limit <= LIMIT_RST;
      cfg_r.short_period   <= SHORT_RST;
      cfg_r.long_period    <= LONG_RST;
      cfg_r.signal_period  <= SIGNAL_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LIMIT:  cfg_r.position_limit <= cfg_pwdata[LIMIT_W-1:0];
        REG_SHORT:  cfg_r.short_period   <= cfg_pwdata[PERIOD_W-1:0];
        REG_LONG:   cfg_r.long_period    <= cfg_pwdata[PERIOD_W-1:0];
        REG_SIGNAL: cfg_r.signal_period  <= cfg_pwdata[PERIOD_W-1:0];
        default:    ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (cfg_idx)
      REG_LIMIT:  cfg_prdata = CFG_DATA_W'(cfg_r.position_limit);
      REG_SHORT:  cfg_prdata = CFG_DATA_W'(cfg_r.short_period);
      REG_LONG:   cfg_prdata = CFG_DATA_W'(cfg_r.long_period);
      REG_SIGNAL: cfg_prdata = CFG_DATA_W'(cfg_r.signal_period);
      default:    cfg_prdata = '0;
    endcase
  end

  mcpt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  mcpt_datapath #(
    .FRAC_BITS  (FRAC_BITS),
    .PRICE_BITS (PRICE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .cfg      (cfg_r),
    .in_price (in_tdata),
    .out_data (out_tdata)
  );

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MACD crossover position tracker. Price samples
// go in as directed values, then as random walks with trending segments plus
// some noise. A per-sample trade predictor (EMAs, crossover, position,
// cashflow, net value) computes each expected record. Both stream sides idle
// at random, and the register settings change between drained phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import mcpt_pkg::*;

  localparam int     FRAC        = 16;
  localparam longint PRICE_MAX   = 64'hFF_FFFF;
  localparam longint AVG_MAX     = PRICE_MAX << FRAC;
  localparam longint CASH_HI     = 64'sh7FFF_FFFF_FFFF;
  localparam longint CASH_LO     = -CASH_HI - 1;
  localparam int     CYCLE_LIMIT = 1_000_000;

  // one expected result record
  typedef struct {
    logic signed [SIG_OUT_W-1:0] macd;
    logic signed [SIG_OUT_W-1:0] sig;
    logic [ACT_W-1:0]            act;
    logic signed [POS_W-1:0]     pos;
    logic signed [CASH_W-1:0]    cash;
    logic signed [CASH_W-1:0]    net;
  } trade_rec_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  macd_crossover_position_tracker_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),     // [23:0] price
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),    // [40:0] macd, [81:41] signal, [83:82] action,
                                 // [94:84] position, [142:95] cashflow,
                                 // [190:143] net value
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state and register shadow
  longint fast_ema, slow_ema, sig_ema, held_units, cash_sum;
  bit     primed;
  longint lim_cfg  = LIMIT_RST;
  longint fast_per = SHORT_RST;
  longint slow_per = LONG_RST;
  longint sig_per  = SIGNAL_RST;

  logic [IN_DATA_W-1:0] price_q[$];
  trade_rec_t           trade_q[$];
  trade_rec_t           due;

  int  samples_queued = 0;
  int  samples_taken  = 0;
  int  results_seen   = 0;
  int  mismatches     = 0;
  int  buys           = 0;
  int  sells          = 0;
  int  peak_pos       = 0;
  int  settings       = 0;
  int  cycle_cnt      = 0;
  int  in_gap         = 0;
  int  out_hold       = 0;
  bit  in_taken       = 1'b0;
  bit  calm           = 1'b0;

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // one EMA update, division truncating toward zero
  function automatic longint ema_next(input longint avg, input longint tgt,
                                      input longint per);
    return avg + ((tgt - avg) * 2) / (per + 1);
  endfunction

  // advance the trading state by one price and build the expected record
  function automatic trade_rec_t trade_step(input logic [IN_DATA_W-1:0] px);
    trade_rec_t r;
    longint     p, macd, net;
    logic [ACT_W-1:0] act;
    p = longint'(px);
    if (!primed) begin
      fast_ema = p << FRAC;
      slow_ema = p << FRAC;
      sig_ema  = 0;
      macd     = 0;
      primed   = 1'b1;
    end else begin
      fast_ema = clip(ema_next(fast_ema, p << FRAC, fast_per), 0, AVG_MAX);
      slow_ema = clip(ema_next(slow_ema, p << FRAC, slow_per), 0, AVG_MAX);
      macd     = fast_ema - slow_ema;
      sig_ema  = clip(ema_next(sig_ema, macd, sig_per), -AVG_MAX, AVG_MAX);
    end
    act = ACT_NONE;
    if (macd > sig_ema && held_units < lim_cfg) begin
      act        = ACT_BUY;
      held_units = held_units + 1;
      cash_sum   = clip(cash_sum - p, CASH_LO, CASH_HI);
      buys++;
    end else if (macd < sig_ema && held_units > -lim_cfg) begin
      act        = ACT_SELL;
      held_units = held_units - 1;
      cash_sum   = clip(cash_sum + p, CASH_LO, CASH_HI);
      sells++;
    end
    net = clip(cash_sum + p * held_units, CASH_LO, CASH_HI);
    if (held_units > peak_pos) peak_pos = int'(held_units);
    if (-held_units > peak_pos) peak_pos = int'(-held_units);
    r.macd = SIG_OUT_W'(macd);
    r.sig  = SIG_OUT_W'(sig_ema);
    r.act  = act;
    r.pos  = POS_W'(held_units);
    r.cash = CASH_W'(cash_sum);
    r.net  = CASH_W'(net);
    return r;
  endfunction

  task automatic note_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= 40)
      $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // idle length: mostly short, a few long
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 100);
  endfunction

  // cycle counter and run limit
  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("[%0t] timeout after %0d cycles", $time, cycle_cnt);
    $display("macd_crossover_position_tracker_unit verification failed");
    $finish;
  end

  // monitor: predict on input transfer, check on result transfer
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        in_taken = 1'b1;
        trade_q = {trade_q, trade_step(in_tdata)};
        samples_taken++;
      end
      if (out_tvalid && out_tready) begin
        if (trade_q.size() == 0) begin
          note_mismatch("result with no sample pending", 0, 0);
        end else begin
          due = trade_q.pop_front();
          results_seen++;
          if ($signed(out_tdata[40:0]) !== due.macd)
            note_mismatch("macd_value", $signed(out_tdata[40:0]), due.macd);
          if ($signed(out_tdata[81:41]) !== due.sig)
            note_mismatch("signal_value", $signed(out_tdata[81:41]), due.sig);
          if (out_tdata[83:82] !== due.act)
            note_mismatch("action", out_tdata[83:82], due.act);
          if ($signed(out_tdata[94:84]) !== due.pos)
            note_mismatch("position", $signed(out_tdata[94:84]), due.pos);
          if ($signed(out_tdata[142:95]) !== due.cash)
            note_mismatch("cashflow", $signed(out_tdata[142:95]), due.cash);
          if ($signed(out_tdata[190:143]) !== due.net)
            note_mismatch("net_value", $signed(out_tdata[190:143]), due.net);
        end
      end
    end
  end

  // input driver, fed from price_q
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (price_q.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= price_q.pop_front();
        in_gap    = pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result-side backpressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_hold > 0) begin
      out_hold--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 5) == 0) out_hold = pick_gap();
    end
  end

  task automatic queue_price(input logic [IN_DATA_W-1:0] p);
    price_q = {price_q, p};
    samples_queued++;
  endtask

  // random walk in trending segments, with some noise samples mixed in
  task automatic queue_walk(input int n, input longint start, input int up_pct);
    longint p, drift, jit;
    int     seg;
    p     = (start < 0) ? longint'($urandom_range(0, 24'hFF_FFFF)) : start;
    seg   = 0;
    drift = 0;
    for (int k = 0; k < n; k++) begin
      if (seg == 0) begin
        seg   = $urandom_range(4, 40);
        drift = longint'(1) << $urandom_range(0, 17);
        if ($urandom_range(1, 100) > up_pct) drift = -drift;
      end
      seg--;
      if ($urandom_range(0, 99) < 8) begin
        queue_price(IN_DATA_W'($urandom));
      end else begin
        jit = longint'($urandom_range(0, 4096)) - 2048;
        p   = clip(p + drift + jit, 0, PRICE_MAX);
        queue_price(IN_DATA_W'(p));
      end
    end
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic reg_check(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] want);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== want) note_mismatch("register readback", cfg_prdata, want);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // write all registers (junk in the unused upper bits), then read back
  task automatic set_regs(input int lim, input int sp, input int lp, input int gp);
    reg_write(REG_LIMIT,  (CFG_DATA_W'($urandom) << LIMIT_W)  | CFG_DATA_W'(lim));
    reg_write(REG_SHORT,  (CFG_DATA_W'($urandom) << PERIOD_W) | CFG_DATA_W'(sp));
    reg_write(REG_LONG,   (CFG_DATA_W'($urandom) << PERIOD_W) | CFG_DATA_W'(lp));
    reg_write(REG_SIGNAL, (CFG_DATA_W'($urandom) << PERIOD_W) | CFG_DATA_W'(gp));
    lim_cfg  = lim;
    fast_per = sp;
    slow_per = lp;
    sig_per  = gp;
    reg_check(REG_LIMIT,  CFG_DATA_W'(lim));
    reg_check(REG_SHORT,  CFG_DATA_W'(sp));
    reg_check(REG_LONG,   CFG_DATA_W'(lp));
    reg_check(REG_SIGNAL, CFG_DATA_W'(gp));
    settings++;
  endtask

  // wait for every queued sample to come back, then let the block settle
  task automatic drain();
    wait (results_seen == samples_queued);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(input int lim, input int sp, input int lp, input int gp,
                           input int n, input longint start, input int up_pct,
                           input bit quiet);
    drain();
    set_regs(lim, sp, lp, gp);
    calm = quiet;
    queue_walk(n, start, up_pct);
  endtask

  // stimulus sequence
  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // reset values
    reg_check(REG_LIMIT,  CFG_DATA_W'(LIMIT_RST));
    reg_check(REG_SHORT,  CFG_DATA_W'(SHORT_RST));
    reg_check(REG_LONG,   CFG_DATA_W'(LONG_RST));
    reg_check(REG_SIGNAL, CFG_DATA_W'(SIGNAL_RST));

    // directed: first sample at full scale, repeats give equal MACD/signal,
    // then swings between the extremes and some bit patterns
    queue_price(24'hFF_FFFF);
    queue_price(24'hFF_FFFF);
    queue_price(24'hFF_FFFF);
    queue_price(24'h00_0000);
    queue_price(24'h00_0000);
    queue_price(24'hFF_FFFF);
    queue_price(24'hFF_FFFF);
    queue_price(24'h00_0001);
    queue_price(24'h80_0000);
    queue_price(24'h7F_FFFF);
    queue_price(24'h55_5555);
    queue_price(24'hAA_AAAA);
    for (int k = 0; k < 4; k++) queue_price(24'd5000);
    queue_price(24'h00_0000);
    queue_price(24'hFF_FFFF);
    queue_price(24'h00_0002);
    queue_price(24'h12_3456);

    // register settings, extremes first
    run_phase(1023, 12,  26,  9,   100, -1,   50, 1'b0);
    run_phase(1023, 1,   255, 1,   100, -1,   50, 1'b1);
    run_phase(0,    3,   7,   2,   60,  -1,   50, 1'b0);
    run_phase(40,   2,   5,   3,   100, 1000, 100, 1'b0);
    // limit lowered under the held position
    run_phase(3,    2,   5,   3,   80,  -1,   50, 1'b0);
    // period zero: divisor of one, clamping
    run_phase(300,  0,   0,   0,   80,  -1,   50, 1'b0);
    run_phase(1023, 255, 255, 255, 80,  -1,   50, 1'b1);
    run_phase(1,    0,   255, 128, 60,  -1,   30, 1'b0);
    for (int k = 0; k < 3; k++)
      run_phase($urandom_range(0, 1023), $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255), 80, -1, $urandom_range(20, 80), 1'b0);

    drain();
    repeat (60) @(posedge clk);
    if (trade_q.size() != 0) note_mismatch("results never delivered", trade_q.size(), 0);

    $display("Covered %0d samples over %0d register settings; %0d records checked.",
             samples_taken, settings, results_seen);
    $display("Trades seen: %0d buys, %0d sells, peak |position| %0d, %0d mismatches.",
             buys, sells, peak_pos, mismatches);
    if (mismatches == 0) begin
      $display("macd_crossover_position_tracker_unit verification clean");
    end else begin
      $display("macd_crossover_position_tracker_unit verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
hdl/mcpt_pkg.sv
hdl/mcpt_divider.sv
hdl/mcpt_datapath.sv
hdl/mcpt_ctrl.sv
hdl/macd_crossover_position_tracker_unit.sv
sim/tb_top.sv
